### rtl/cnco_pkg.sv
// shared types, constants and arithmetic helpers for the carrier nco down-converter
package cnco_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int TABLE_SIZE  = 64;
    localparam int PHASE_W     = 32;
    localparam int INDEX_W     = $clog2(TABLE_SIZE);
    localparam int LO_W        = 5;
    localparam int CYCLE_W     = 32;
    localparam int OUT_W       = 6;
    localparam int SUM_W       = 24;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int SAT_LIMIT   = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_STEP   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRE_SHIFT_MODE = 1'b1;

    typedef enum logic [1:0] {
        SHIFT_CONV3  = 2'd0,
        SHIFT_CONV4  = 2'd1,
        SHIFT_CONV5  = 2'd2,
        SHIFT_TRUNC3 = 2'd3
    } shift_mode_t;

    // cosine column of the local carrier; the minus-sine column is the same table a quarter turn on
    localparam logic signed [LO_W-1:0] CARRIER_TABLE [TABLE_SIZE] = '{
        5'sd12,  5'sd12,  5'sd12,  5'sd11,  5'sd11,  5'sd10,  5'sd10,  5'sd9,
        5'sd8,   5'sd7,   5'sd6,   5'sd5,   5'sd4,   5'sd3,   5'sd2,   5'sd1,
        -5'sd1,  -5'sd2,  -5'sd3,  -5'sd4,  -5'sd5,  -5'sd6,  -5'sd7,  -5'sd8,
        -5'sd9,  -5'sd10, -5'sd10, -5'sd11, -5'sd11, -5'sd12, -5'sd12, -5'sd12,
        -5'sd12, -5'sd12, -5'sd12, -5'sd11, -5'sd11, -5'sd10, -5'sd10, -5'sd9,
        -5'sd8,  -5'sd7,  -5'sd6,  -5'sd5,  -5'sd4,  -5'sd3,  -5'sd2,  -5'sd1,
        5'sd1,   5'sd2,   5'sd3,   5'sd4,   5'sd5,   5'sd6,   5'sd7,   5'sd8,
        5'sd9,   5'sd10,  5'sd10,  5'sd11,  5'sd11,  5'sd12,  5'sd12,  5'sd12
    };

    function automatic logic signed [LO_W-1:0] lo_real(input logic [INDEX_W-1:0] idx);
        lo_real = CARRIER_TABLE[idx];
    endfunction

    function automatic logic signed [LO_W-1:0] lo_imag(input logic [INDEX_W-1:0] idx);
        logic [INDEX_W-1:0] rot;
        rot     = idx + INDEX_W'(TABLE_SIZE / 4);
        lo_imag = CARRIER_TABLE[rot];
    endfunction

    // right shift with round half to even or floor, then clamp to +-31
    function automatic logic signed [OUT_W-1:0] scale_sat(
        input logic signed [SUM_W-1:0] x,
        input shift_mode_t             mode
    );
        logic signed [SUM_W-1:0] q;
        logic signed [SUM_W-1:0] qr;
        logic [4:0]              rem;
        logic [4:0]              half;
        logic                    conv;
        logic                    up;
        case (mode)
            SHIFT_CONV3:
            begin
                q    = x >>> 3;
                rem  = {2'b00, x[2:0]};
                half = 5'd4;
                conv = 1'b1;
            end
            SHIFT_CONV4:
            begin
                q    = x >>> 4;
                rem  = {1'b0, x[3:0]};
                half = 5'd8;
                conv = 1'b1;
            end
            SHIFT_CONV5:
            begin
                q    = x >>> 5;
                rem  = x[4:0];
                half = 5'd16;
                conv = 1'b1;
            end
            default:
            begin
                q    = x >>> 3;
                rem  = {2'b00, x[2:0]};
                half = 5'd4;
                conv = 1'b0;
            end
        endcase
        up = conv && ((rem > half) || ((rem == half) && q[0]));
        qr = q + SUM_W'(up);
        if (qr > SUM_W'(SAT_LIMIT))
            scale_sat = OUT_W'(SAT_LIMIT);
        else if (qr < -SUM_W'(SAT_LIMIT))
            scale_sat = -OUT_W'(SAT_LIMIT);
        else
            scale_sat = qr[OUT_W-1:0];
    endfunction

endpackage

### rtl/cnco_if.sv
// channel interfaces: input samples and mixed results
interface cnco_sample_if #(
    parameter int SAMPLE_BITS = cnco_pkg::SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_real;
    logic signed [SAMPLE_BITS-1:0] in_imag;
    logic                          in_last;

    modport source (output valid, in_real, in_imag, in_last, input ready);
    modport sink   (input valid, in_real, in_imag, in_last, output ready);
endinterface

interface cnco_mix_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cnco_pkg::OUT_W-1:0]     out_real;
    logic signed [cnco_pkg::OUT_W-1:0]     out_imag;
    logic signed [cnco_pkg::CYCLE_W-1:0]   cycle_count;
    logic                                  out_last;

    modport source (output valid, out_real, out_imag, cycle_count, out_last, input ready);
    modport sink   (input valid, out_real, out_imag, cycle_count, out_last, output ready);
endinterface

### rtl/carrier_nco_down_converter.sv
// top level: carrier wipe-off with nco, queue and mixer, plus configuration registers
//
//  channel   dir  handshake      payload
//  samples   in   valid/ready    in_real, in_imag, in_last
//  mixed     out  valid/ready    out_real, out_imag, cycle_count, out_last
//  cfg       in   cfg_we         cfg_index, cfg_data (0: carrier_step, 1: pre_shift_mode)
//
// one sample per cycle sustained while the output is taken; a taken sample passes through
// the queue register, the product register and the output register, in that order
// the front end stalls only when the two-entry queue is full; while the output register holds
// an item nobody takes, a full product register waits too and an empty one still fills
// reset clears phase, cycle counter, configuration and all valid flags
module carrier_nco_down_converter #(
    parameter int SAMPLE_BITS = cnco_pkg::SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cnco_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cnco_pkg::CFG_DATA_W-1:0]     cfg_data,
    cnco_sample_if.sink                         samples,
    cnco_mix_if.source                          mixed
);

    localparam int ENTRY_W = 2 * SAMPLE_BITS + 2 * cnco_pkg::LO_W + cnco_pkg::CYCLE_W + 1;

    logic [cnco_pkg::PHASE_W-1:0] carrier_step_reg;
    cnco_pkg::shift_mode_t        pre_shift_mode_reg;

    logic                         push_valid;
    logic                         push_ready;
    logic [ENTRY_W-1:0]           push_data;
    logic                         pop_valid;
    logic                         pop_ready;
    logic [ENTRY_W-1:0]           pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_step_reg   <= '0;
            pre_shift_mode_reg <= cnco_pkg::SHIFT_CONV3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cnco_pkg::CFG_CARRIER_STEP:
                    carrier_step_reg <= cfg_data[cnco_pkg::PHASE_W-1:0];
                cnco_pkg::CFG_PRE_SHIFT_MODE:
                    pre_shift_mode_reg <= cnco_pkg::shift_mode_t'(cfg_data[1:0]);
                default:
                begin
                end
            endcase
        end
    end

    cnco_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples),
        .carrier_step (carrier_step_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    cnco_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cnco_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_mixer (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .pre_shift_mode (pre_shift_mode_reg),
        .mixed          (mixed)
    );

endmodule

### rtl/cnco_front.sv
// front end: phase accumulator, cycle counter and carrier table lookup
module cnco_front #(
    parameter int SAMPLE_BITS = cnco_pkg::SAMPLE_BITS,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + 2 * cnco_pkg::LO_W + cnco_pkg::CYCLE_W + 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cnco_sample_if.sink                       samples,
    input  logic [cnco_pkg::PHASE_W-1:0]      carrier_step,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [ENTRY_W-1:0]                push_data
);

    logic [cnco_pkg::PHASE_W-1:0] phase_reg;
    logic [cnco_pkg::PHASE_W-1:0] phase_next;
    logic [cnco_pkg::CYCLE_W-1:0] count_reg;
    logic [cnco_pkg::CYCLE_W-1:0] count_next;
    logic [cnco_pkg::PHASE_W:0]   sum;
    logic [cnco_pkg::INDEX_W-1:0] idx;
    logic                         accept;

    assign samples.ready = push_ready;
    assign accept        = samples.valid && push_ready;
    assign push_valid    = samples.valid;

    assign sum        = {1'b0, phase_reg} + {1'b0, carrier_step};
    assign phase_next = sum[cnco_pkg::PHASE_W-1:0];
    assign idx        = phase_reg[cnco_pkg::PHASE_W-1 -: cnco_pkg::INDEX_W];

    // carry out marks a wrap going up; no carry with a negative step marks a wrap going down
    always_comb
    begin
        count_next = count_reg;
        if (carrier_step[cnco_pkg::PHASE_W-1])
        begin
            if (!sum[cnco_pkg::PHASE_W])
                count_next = count_reg - 1'b1;
        end
        else if (sum[cnco_pkg::PHASE_W])
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign push_data = {samples.in_real, samples.in_imag,
                        cnco_pkg::lo_real(idx), cnco_pkg::lo_imag(idx),
                        count_next, samples.in_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/cnco_queue.sv
// short queue between the front end and the mixer
module cnco_queue #(
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int DEPTH = cnco_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

### rtl/cnco_mixer.sv
// back end: complex multiply, rescale and saturate, output register
module cnco_mixer #(
    parameter int SAMPLE_BITS = cnco_pkg::SAMPLE_BITS,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + 2 * cnco_pkg::LO_W + cnco_pkg::CYCLE_W + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [ENTRY_W-1:0]    pop_data,
    input  cnco_pkg::shift_mode_t pre_shift_mode,
    cnco_mix_if.source            mixed
);

    localparam int PROD_W = SAMPLE_BITS + cnco_pkg::LO_W;
    localparam int LO_W   = cnco_pkg::LO_W;
    localparam int SUM_W  = cnco_pkg::SUM_W;

    logic signed [SAMPLE_BITS-1:0]       a;
    logic signed [SAMPLE_BITS-1:0]       b;
    logic signed [LO_W-1:0]              c;
    logic signed [LO_W-1:0]              d;
    logic [cnco_pkg::CYCLE_W-1:0]        cnt;
    logic                                last;

    logic                                s1_valid_reg;
    logic signed [PROD_W-1:0]            p_ac_reg;
    logic signed [PROD_W-1:0]            p_bd_reg;
    logic signed [PROD_W-1:0]            p_ad_reg;
    logic signed [PROD_W-1:0]            p_bc_reg;
    logic [cnco_pkg::CYCLE_W-1:0]        s1_cnt_reg;
    logic                                s1_last_reg;

    logic                                out_valid_reg;
    logic signed [cnco_pkg::OUT_W-1:0]   out_real_reg;
    logic signed [cnco_pkg::OUT_W-1:0]   out_imag_reg;
    logic [cnco_pkg::CYCLE_W-1:0]        out_cnt_reg;
    logic                                out_last_reg;

    logic signed [SUM_W-1:0]             sum_re;
    logic signed [SUM_W-1:0]             sum_im;
    logic                                adv;
    logic                                s1_en;

    assign {a, b, c, d, cnt, last} = pop_data;

    // the pipe moves when the output register frees up; an empty product register still fills
    assign adv       = !out_valid_reg || mixed.ready;
    assign s1_en     = !s1_valid_reg || adv;
    assign pop_ready = s1_en;

    assign sum_re = SUM_W'(p_ac_reg) - SUM_W'(p_bd_reg);
    assign sum_im = SUM_W'(p_ad_reg) + SUM_W'(p_bc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= pop_valid;
            if (adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && pop_valid)
        begin
            p_ac_reg    <= a * c;
            p_bd_reg    <= b * d;
            p_ad_reg    <= a * d;
            p_bc_reg    <= b * c;
            s1_cnt_reg  <= cnt;
            s1_last_reg <= last;
        end
        if (adv && s1_valid_reg)
        begin
            out_real_reg <= cnco_pkg::scale_sat(sum_re, pre_shift_mode);
            out_imag_reg <= cnco_pkg::scale_sat(sum_im, pre_shift_mode);
            out_cnt_reg  <= s1_cnt_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign mixed.valid       = out_valid_reg;
    assign mixed.out_real    = out_real_reg;
    assign mixed.out_imag    = out_imag_reg;
    assign mixed.cycle_count = out_cnt_reg;
    assign mixed.out_last    = out_last_reg;

endmodule

### tb/sv/cnco_check_pkg.sv
// result record and scoreboard with its own carrier nco and mixer predictor
package cnco_check_pkg;

    import cnco_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0]   re;
        logic signed [OUT_W-1:0]   im;
        logic signed [CYCLE_W-1:0] cycles;
        logic                      last;
    } mix_result_t;

    // local carrier cosine; the minus-sine column is the same list a quarter turn later
    localparam int LO_COS [64] = '{
         12,  12,  12,  11,  11,  10,  10,   9,   8,   7,   6,   5,   4,   3,   2,   1,
         -1,  -2,  -3,  -4,  -5,  -6,  -7,  -8,  -9, -10, -10, -11, -11, -12, -12, -12,
        -12, -12, -12, -11, -11, -10, -10,  -9,  -8,  -7,  -6,  -5,  -4,  -3,  -2,  -1,
          1,   2,   3,   4,   5,   6,   7,   8,   9,  10,  10,  11,  11,  12,  12,  12
    };

    class mix_scoreboard;
        logic [PHASE_W-1:0] step;
        shift_mode_t        mode;
        logic [PHASE_W-1:0] phase;
        logic [CYCLE_W-1:0] cycles;
        mix_result_t        expected_q[$];
        int                 errors;

        function new();
            step   = '0;
            mode   = SHIFT_CONV3;
            phase  = '0;
            cycles = '0;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_CARRIER_STEP)
                step = data;
            else if (index == CFG_PRE_SHIFT_MODE)
                mode = shift_mode_t'(data[1:0]);
        endfunction

        function int shift_clamp(int x);
            int s;
            bit conv;
            int q;
            int rem;
            int half;
            case (mode)
                SHIFT_CONV3:  begin s = 3; conv = 1'b1; end
                SHIFT_CONV4:  begin s = 4; conv = 1'b1; end
                SHIFT_CONV5:  begin s = 5; conv = 1'b1; end
                default:      begin s = 3; conv = 1'b0; end
            endcase
            q    = x >>> s;
            rem  = x & ((1 << s) - 1);
            half = 1 << (s - 1);
            // ties go to the even neighbor
            if (conv && (rem > half || (rem == half && q[0])))
                q++;
            if (q > cnco_pkg::SAT_LIMIT)
                q = cnco_pkg::SAT_LIMIT;
            else if (q < -cnco_pkg::SAT_LIMIT)
                q = -cnco_pkg::SAT_LIMIT;
            return q;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] re_in,
                                  logic signed [SAMPLE_BITS-1:0] im_in,
                                  logic last);
            logic [INDEX_W-1:0] idx;
            logic [PHASE_W-1:0] next;
            int a;
            int b;
            int c;
            int d;
            mix_result_t res;
            idx  = phase[PHASE_W-1 -: INDEX_W];
            c    = LO_COS[idx];
            d    = LO_COS[INDEX_W'(idx + 6'd16)];
            next = phase + step;
            // wrap direction follows the sign of the step
            if (step[PHASE_W-1])
            begin
                if (next > phase)
                    cycles = cycles - 1;
            end
            else if (next < phase)
                cycles = cycles + 1;
            phase      = next;
            a          = re_in;
            b          = im_in;
            res.re     = OUT_W'(shift_clamp(a * c - b * d));
            res.im     = OUT_W'(shift_clamp(a * d + b * c));
            res.cycles = cycles;
            res.last   = last;
            expected_q.push_back(res);
        endfunction

        function void check_result(mix_result_t got);
            mix_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got re %0d im %0d cycles %0d last %0b",
                         $time, got.re, got.im, got.cycles, got.last);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.re !== exp_res.re)
            begin
                $display("%0t: out_real: expected %0d, got %0d", $time, exp_res.re, got.re);
                errors++;
            end
            if (got.im !== exp_res.im)
            begin
                $display("%0t: out_imag: expected %0d, got %0d", $time, exp_res.im, got.im);
                errors++;
            end
            if (got.cycles !== exp_res.cycles)
            begin
                $display("%0t: cycle_count: expected %0d, got %0d", $time, exp_res.cycles,
                         got.cycles);
                errors++;
            end
            if (got.last !== exp_res.last)
            begin
                $display("%0t: out_last: expected %0b, got %0b", $time, exp_res.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

### tb/sv/tb.sv
// top of the carrier nco down-converter testbench: clock, reset, stimulus and result checks
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cnco_pkg::*;
    import cnco_check_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cnco_sample_if samples_ch();
    cnco_mix_if    mixed_ch();

    carrier_nco_down_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .mixed     (mixed_ch)
    );

    mix_scoreboard sb = new();

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;
    int sent_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] re_in,
                               logic signed [SAMPLE_BITS-1:0] im_in,
                               logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid   <= 1'b1;
        samples_ch.in_real <= re_in;
        samples_ch.in_imag <= im_in;
        samples_ch.in_last <= last;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        sb.note_sample(re_in, im_in, last);
        sent_count++;
    endtask

    task automatic send_random();
        send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // leaves valid low until every expected item is back
    task automatic drain_results();
        samples_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_mode(shift_mode_t m);
        write_register(CFG_PRE_SHIFT_MODE, {30'($urandom), 2'(m)});
    endtask

    // receiver: one decision per cycle, a long hold takes priority over the normal stall
    initial
    begin
        int stall_left;
        mix_result_t got;
        stall_left = 0;
        mixed_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mixed_ch.valid && mixed_ch.ready)
            begin
                got.re     = mixed_ch.out_real;
                got.im     = mixed_ch.out_imag;
                got.cycles = mixed_ch.cycle_count;
                got.last   = mixed_ch.out_last;
                sb.check_result(got);
                stall_left = rx_idle ? $urandom_range(0, 17) : 0;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                mixed_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                mixed_ch.ready <= 1'b0;
            end
            else
                mixed_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int burst;
        int pause_at;
        int phase_no;
        logic [31:0] step_val;
        bit pressure;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_CARRIER_STEP;
        cfg_data           <= '0;
        samples_ch.valid   <= 1'b0;
        samples_ch.in_real <= '0;
        samples_ch.in_imag <= '0;
        samples_ch.in_last <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero step, convergent shift by 3, table entry 0
        send_sample(8'sd0, 8'sd0, 1'b0);
        send_sample(8'sd127, 8'sd127, 1'b1);
        send_sample(-8'sd128, -8'sd128, 1'b0);
        send_sample(8'sd127, -8'sd128, 1'b0);
        send_sample(-8'sd128, 8'sd127, 1'b1);
        send_sample(8'sd0, 8'sd4, 1'b0);
        send_sample(8'sd0, 8'sd12, 1'b0);
        send_sample(8'sd0, -8'sd4, 1'b0);
        send_sample(8'sd1, 8'sd0, 1'b0);
        drain_results();

        // truncating, one table entry per item
        write_register(CFG_CARRIER_STEP, 32'h0400_0000);
        write_mode(SHIFT_TRUNC3);
        repeat (8) send_random();
        drain_results();

        // half-turn negative step wraps on every second item
        write_register(CFG_CARRIER_STEP, 32'h8000_0000);
        write_mode(SHIFT_CONV4);
        send_sample(-8'sd128, 8'sd127, 1'b0);
        send_sample(8'sd127, 8'sd127, 1'b1);
        send_sample(-8'sd1, -8'sd1, 1'b0);
        send_sample(8'sd5, -8'sd3, 1'b0);
        drain_results();

        write_register(CFG_CARRIER_STEP, 32'h7fff_ffff);
        write_mode(SHIFT_CONV5);
        repeat (4) send_random();

        phase_no = 0;
        while (sent_count < 650)
        begin
            drain_results();
            case ($urandom_range(0, 5))
                0: step_val = $urandom;
                1: step_val = $urandom_range(1, 32'h1000_0000);
                2: step_val = -$urandom_range(1, 32'h1000_0000);
                3:
                begin
                    case ($urandom_range(0, 4))
                        0: step_val = 32'h0000_0000;
                        1: step_val = 32'h0000_0001;
                        2: step_val = 32'h7fff_ffff;
                        3: step_val = 32'h8000_0000;
                        default: step_val = 32'hffff_ffff;
                    endcase
                end
                4: step_val = {6'($urandom), 26'd0};
                default: step_val = sb.step;
            endcase
            write_register(CFG_CARRIER_STEP, step_val);
            write_mode(shift_mode_t'($urandom_range(0, 3)));
            tx_idle  = $urandom_range(0, 3) != 0;
            rx_idle  = $urandom_range(0, 3) != 0;
            burst    = $urandom_range(8, 48);
            pressure = (phase_no == 0) || ($urandom_range(0, 5) == 0);
            if (pressure)
            begin
                // sender keeps offering while the output is held off
                tx_idle = 1'b0;
                rx_hold = $urandom_range(40, 80);
            end
            pause_at = (phase_no == 1 || $urandom_range(0, 3) == 0) ?
                       $urandom_range(1, burst - 1) : -1;
            for (int k = 0; k < burst; k++)
            begin
                if (k == pause_at)
                    drain_results();
                send_random();
            end
            phase_no++;
        end

        samples_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
